// ===== hdl/upd_pkg.sv =====
package upd_pkg;

   // decoder phases
   typedef enum logic [1:0] {
      PH_SKIP  = 2'd0,
      PH_COPY  = 2'd1,
      PH_PCT   = 2'd2,
      PH_DIGIT = 2'd3
   } phase_type;

   // characters with a meaning of their own
   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_PCT   = 8'h25;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_0     = 8'h30;
   localparam logic [7:0] CHAR_9     = 8'h39;
   localparam logic [7:0] CHAR_UA    = 8'h41;
   localparam logic [7:0] CHAR_UF    = 8'h46;
   localparam logic [7:0] CHAR_LA    = 8'h61;
   localparam logic [7:0] CHAR_LF    = 8'h66;

   // offset from the low nibble of a letter to its hex value
   localparam logic [3:0] LETTER_OFFSET = 4'd9;

   // results one item can cause
   localparam int unsigned MAX_RESULTS = 3;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } rsp_entry_type;

   // decoded results of one item, entry 0 goes out first
   typedef struct packed {
      logic [1:0]                        count;
      rsp_entry_type [MAX_RESULTS-1:0]   ent;
   } dec_out_type;

   // result buffer status towards the input stage
   typedef struct packed {
      logic       load_ok;
      logic [1:0] count;
   } buf_status_type;

   function automatic logic is_ws(input logic [7:0] c);
      return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CHAR_0) && (c <= CHAR_9);
   endfunction

   function automatic logic is_hex(input logic [7:0] c);
      return is_digit(c) || ((c >= CHAR_UA) && (c <= CHAR_UF)) ||
             ((c >= CHAR_LA) && (c <= CHAR_LF));
   endfunction

   // nibble value of a hex digit, letters of either case
   function automatic logic [3:0] hex_val(input logic [7:0] c);
      return is_digit(c) ? c[3:0] : (c[3:0] + LETTER_OFFSET);
   endfunction

endpackage

// ===== hdl/upd_decode.sv =====
module upd_decode (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic [7:0]           in_byte,
   output upd_pkg::dec_out_type dec_out
);

   upd_pkg::phase_type     phase_ff, phase_in;
   logic [7:0]             held_ff, held_in;
   logic                   cp_emit;
   upd_pkg::rsp_entry_type cp_ent;
   upd_pkg::phase_type     cp_phase;
   upd_pkg::rsp_entry_type pct_ent;

   // handling of a byte as in the copying phase
   always_comb begin
      cp_emit  = 1'b1;
      cp_ent   = '{data: in_byte, last: 1'b0};
      cp_phase = upd_pkg::PH_COPY;
      priority if (in_byte == upd_pkg::CHAR_NUL) begin
         cp_ent   = '{data: upd_pkg::CHAR_NUL, last: 1'b1};
         cp_phase = upd_pkg::PH_SKIP;
      end else if (in_byte == upd_pkg::CHAR_PLUS) begin
         cp_ent = '{data: upd_pkg::CHAR_SPACE, last: 1'b0};
      end else if (in_byte == upd_pkg::CHAR_PCT) begin
         cp_emit  = 1'b0;
         cp_phase = upd_pkg::PH_PCT;
      end else begin
         // ordinary byte goes out as it is
         cp_ent = '{data: in_byte, last: 1'b0};
      end
   end

   // per phase results and next state
   always_comb begin
      pct_ent  = '{data: upd_pkg::CHAR_PCT, last: 1'b0};
      dec_out  = '0;
      phase_in = phase_ff;
      held_in  = held_ff;
      unique case (phase_ff)
         upd_pkg::PH_SKIP: begin
            if (!upd_pkg::is_ws(in_byte)) begin
               dec_out.count  = {1'b0, cp_emit};
               dec_out.ent[0] = cp_ent;
               phase_in       = cp_phase;
            end
         end
         upd_pkg::PH_COPY: begin
            dec_out.count  = {1'b0, cp_emit};
            dec_out.ent[0] = cp_ent;
            phase_in       = cp_phase;
         end
         upd_pkg::PH_PCT: begin
            if (upd_pkg::is_hex(in_byte)) begin
               held_in  = in_byte;
               phase_in = upd_pkg::PH_DIGIT;
            end else begin
               dec_out.count  = 2'd1 + {1'b0, cp_emit};
               dec_out.ent[0] = pct_ent;
               dec_out.ent[1] = cp_ent;
               phase_in       = cp_phase;
            end
         end
         upd_pkg::PH_DIGIT: begin
            if (upd_pkg::is_hex(in_byte)) begin
               dec_out.count  = 2'd1;
               dec_out.ent[0] = '{data: {upd_pkg::hex_val(held_ff),
                                         upd_pkg::hex_val(in_byte)},
                                  last: 1'b0};
               phase_in       = upd_pkg::PH_COPY;
            end else begin
               dec_out.count  = 2'd2 + {1'b0, cp_emit};
               dec_out.ent[0] = pct_ent;
               dec_out.ent[1] = '{data: held_ff, last: 1'b0};
               dec_out.ent[2] = cp_ent;
               phase_in       = cp_phase;
            end
         end
      endcase
   end

   // state update once the item moves on
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= upd_pkg::PH_SKIP;
         held_ff  <= '0;
      end else if (advance) begin
         phase_ff <= phase_in;
         held_ff  <= held_in;
      end
   end

endmodule

// ===== hdl/upd_rsp_buf.sv =====
module upd_rsp_buf (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  upd_pkg::dec_out_type    dec_out,
   output upd_pkg::buf_status_type status,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [7:0]              rsp_tdata,
   output logic                    rsp_tlast
);

   upd_pkg::rsp_entry_type [upd_pkg::MAX_RESULTS-1:0] ent_ff;
   logic [1:0] count_ff;
   logic       pop;

   assign pop            = (count_ff != 2'd0) && rsp_tready;
   assign status.count   = count_ff;
   assign status.load_ok = (count_ff == 2'd0) || ((count_ff == 2'd1) && pop);

   assign rsp_tvalid = (count_ff != 2'd0);
   assign rsp_tdata  = ent_ff[0].data;
   assign rsp_tlast  = ent_ff[0].last;

   // fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (load) begin
         count_ff <= dec_out.count;
      end else if (pop) begin
         count_ff <= count_ff - 2'd1;
      end
   end

   // result entries, entry 0 faces the port
   always_ff @(posedge clock) begin
      if (load) begin
         ent_ff <= dec_out.ent;
      end else if (pop) begin
         ent_ff[0] <= ent_ff[1];
         ent_ff[1] <= ent_ff[2];
      end
   end

endmodule

// ===== hdl/url_percent_decoder_core.sv =====
// channel   direction  tdata              tuser/tlast
// req       in         [7:0] in_byte      -
// rsp       out        [7:0] out_byte     tlast = out_last
//
// at most one input item per cycle while req_tready is high; each item yields
// zero to three result items, sent one per cycle while rsp_tready is high.
// the path runs through the input register and then the result buffer.
// the input register takes a new item whenever the buffer can load.
// synchronous active-high reset returns to whitespace skipping.
// stalls on rsp hold the buffer and, through it, the req channel.
module url_percent_decoder_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tlast
);

   logic                    in_valid_ff;
   logic [7:0]              in_byte_ff;
   logic                    advance;
   upd_pkg::dec_out_type    dec_out;
   upd_pkg::buf_status_type status;

   assign advance    = in_valid_ff && status.load_ok;
   assign req_tready = !in_valid_ff || advance;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
      end
   end

   upd_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .in_byte (in_byte_ff),
      .dec_out (dec_out)
   );

   upd_rsp_buf u_rsp_buf (
      .clock      (clock),
      .reset      (reset),
      .load       (advance),
      .dec_out    (dec_out),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // buffer never holds more than one item's results
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      status.count <= 2'd3)
      else $error("result buffer overfilled");

   // a terminator always produces a result
   a_nul_out: assert property (@(posedge clock) disable iff (reset)
      (advance && (in_byte_ff == upd_pkg::CHAR_NUL)) |=> rsp_tvalid)
      else $error("terminator gave no result");

   // a loaded terminator set is closed by a last flag
   a_nul_last: assert property (@(posedge clock) disable iff (reset)
      (advance && (in_byte_ff == upd_pkg::CHAR_NUL)) |->
         dec_out.ent[dec_out.count - 2'd1].last)
      else $error("terminator result without last");

endmodule
